// File: rtl/core/pts_pkg.sv
package pts_pkg;

    // Most reports one run pass may produce before the scan stops
    localparam int unsigned MAX_REPORTS = 16;
    // Wide enough to count up to MAX_REPORTS fires
    localparam int unsigned FIRE_W = $clog2(MAX_REPORTS + 1);

    // Input op codes
    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_RUN      = 1'b1;

    // Result kind codes
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // One result word
    typedef struct packed {
        logic       kind;
        logic       accepted;
        logic [3:0] task_index;
        logic       fired;
        logic       last;
    } t_report;

endpackage

// File: rtl/core/pts_task_mem.sv
module pts_task_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_per_we,
    input  logic          i_lr_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_per_wdata,
    input  logic [31:0]   i_lr_wdata,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_per_rdata,
    output logic [31:0]   o_lr_rdata
);

    logic [31:0] r_per_mem [DEPTH];
    logic [31:0] r_lr_mem  [DEPTH];
    logic [31:0] r_per_rd;
    logic [31:0] r_lr_rd;

    // Period table: written on register
    always_ff @(posedge i_clk) begin
        if (i_per_we) begin
            r_per_mem[i_wr_addr] <= i_per_wdata;
        end
        if (i_rd_en) begin
            r_per_rd <= r_per_mem[i_rd_addr];
        end
    end

    // Last-run table: written on register and on fire
    always_ff @(posedge i_clk) begin
        if (i_lr_we) begin
            r_lr_mem[i_wr_addr] <= i_lr_wdata;
        end
        if (i_rd_en) begin
            r_lr_rd <= r_lr_mem[i_rd_addr];
        end
    end

    assign o_per_rdata = r_per_rd;
    assign o_lr_rdata  = r_lr_rd;

endmodule

// File: rtl/core/pts_out_reg.sv
module pts_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pts_pkg::t_report i_rep,
    output logic             o_can_push,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output pts_pkg::t_report o_rep
);

    logic             r_valid;
    pts_pkg::t_report r_rep;

    // Slot frees up in the same cycle the held word is taken
    assign o_can_push = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_push) begin
            r_valid <= i_push;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_push && o_can_push) begin
            r_rep <= i_rep;
        end
    end

    assign o_out_valid = r_valid;
    assign o_rep       = r_rep;

endmodule

// File: rtl/core/periodic_task_scheduler_unit.sv
// Channel   Direction  Handshake                  Word
// input     in         i_in_valid / o_in_ready    i_op, i_now, i_period, i_start_delay
// output    out        o_out_valid / i_out_ready  o_kind, o_accepted, o_task_index,
//                                                 o_fired, o_last
//
// Register: accepted in idle; reply pushed from the done state to the output register.
// Run pass: one slot per cycle through the single read port of the task memory
//   while the scan is not stalled; new items are taken only once back in idle.
// A fired slot is held in the pending word so its last flag is known; the scan stalls
//   only when a new fire finds that slot still waiting for the full output register.
// Reset empties the table (task count to zero); the task memory is not cleared.
module periodic_task_scheduler_unit #(
    parameter int unsigned TASK_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [31:0] i_now,
    input  logic [31:0] i_period,
    input  logic [31:0] i_start_delay,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic        o_accepted,
    output logic [3:0]  o_task_index,
    output logic        o_fired,
    output logic        o_last
);

    localparam int unsigned IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(TASK_SLOTS + 1);

    pts_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_scan, n_scan;
    logic [pts_pkg::FIRE_W-1:0] r_fires, n_fires;
    logic [31:0]      r_now, n_now;
    pts_pkg::t_report r_pend, n_pend;

    // Memory port signals
    logic             w_per_we, w_lr_we, w_rd_en;
    logic [IDX_W-1:0] w_wr_addr, w_rd_addr;
    logic [31:0]      w_per_wdata, w_lr_wdata;
    logic [31:0]      w_per_rdata, w_lr_rdata;

    // Output register signals
    logic             w_push, w_can_push;
    pts_pkg::t_report w_rep, w_out_rep;

    logic             w_full, w_fire, w_stall, w_last_slot, w_done;
    logic [31:0]      w_elapsed;
    logic [IDX_W+3:0] w_count_ext, w_scan_ext;

    pts_task_mem #(
        .DEPTH (TASK_SLOTS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_per_we    (w_per_we),
        .i_lr_we     (w_lr_we),
        .i_wr_addr   (w_wr_addr),
        .i_per_wdata (w_per_wdata),
        .i_lr_wdata  (w_lr_wdata),
        .i_rd_en     (w_rd_en),
        .i_rd_addr   (w_rd_addr),
        .o_per_rdata (w_per_rdata),
        .o_lr_rdata  (w_lr_rdata)
    );

    pts_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_rep       (w_rep),
        .o_can_push  (w_can_push),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_rep       (w_out_rep)
    );

    assign o_kind       = w_out_rep.kind;
    assign o_accepted   = w_out_rep.accepted;
    assign o_task_index = w_out_rep.task_index;
    assign o_fired      = w_out_rep.fired;
    assign o_last       = w_out_rep.last;

    // Slot numbers reported on 4 bits
    assign w_count_ext = {4'b0, r_count[IDX_W-1:0]};
    assign w_scan_ext  = {4'b0, r_scan};

    assign w_full      = (r_count == CNT_W'(TASK_SLOTS));
    assign w_elapsed   = r_now - w_lr_rdata;
    assign w_fire      = (w_elapsed >= w_per_rdata);
    // A second fire cannot be taken while the earlier one still waits to go out
    assign w_stall     = w_fire && r_pend.fired && !w_can_push;
    assign w_last_slot = ((CNT_W'(r_scan) + CNT_W'(1)) == r_count);
    assign w_done      = w_last_slot ||
                         (w_fire && (r_fires == pts_pkg::FIRE_W'(pts_pkg::MAX_REPORTS - 1)));

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pts_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan  <= n_scan;
        r_fires <= n_fires;
        r_now   <= n_now;
        r_pend  <= n_pend;
    end

    // Sequencer: next state, memory access, report push
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan      = r_scan;
        n_fires     = r_fires;
        n_now       = r_now;
        n_pend      = r_pend;
        o_in_ready  = 1'b0;
        w_per_we    = 1'b0;
        w_lr_we     = 1'b0;
        w_wr_addr   = r_scan;
        w_per_wdata = i_period;
        w_lr_wdata  = r_now;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_scan + IDX_W'(1);
        w_push      = 1'b0;
        w_rep       = r_pend;
        w_rep.last  = 1'b0;
        case (r_state)
            pts_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_now = i_now;
                    if (i_op == pts_pkg::OP_REGISTER) begin
                        n_pend.kind       = pts_pkg::KIND_REPLY;
                        n_pend.accepted   = 1'b0;
                        n_pend.task_index = 4'd0;
                        n_pend.fired      = 1'b0;
                        n_pend.last       = 1'b1;
                        if (!w_full) begin
                            w_per_we          = 1'b1;
                            w_lr_we           = 1'b1;
                            w_wr_addr         = r_count[IDX_W-1:0];
                            w_lr_wdata        = i_now + i_start_delay - i_period;
                            n_count           = r_count + CNT_W'(1);
                            n_pend.accepted   = 1'b1;
                            n_pend.task_index = w_count_ext[3:0];
                        end
                        n_state = pts_pkg::ST_DONE;
                    end else begin
                        n_pend.kind       = pts_pkg::KIND_RUN;
                        n_pend.accepted   = 1'b0;
                        n_pend.task_index = 4'd0;
                        n_pend.fired      = 1'b0;
                        n_pend.last       = 1'b1;
                        n_fires           = '0;
                        n_scan            = '0;
                        if (r_count == '0) begin
                            n_state = pts_pkg::ST_DONE;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                            n_state   = pts_pkg::ST_SCAN;
                        end
                    end
                end
            end
            pts_pkg::ST_SCAN: begin
                if (!w_stall) begin
                    if (w_fire) begin
                        w_lr_we           = 1'b1;
                        w_push            = r_pend.fired;
                        n_pend.kind       = pts_pkg::KIND_RUN;
                        n_pend.accepted   = 1'b0;
                        n_pend.task_index = w_scan_ext[3:0];
                        n_pend.fired      = 1'b1;
                        n_fires           = r_fires + pts_pkg::FIRE_W'(1);
                    end
                    if (w_done) begin
                        n_state = pts_pkg::ST_DONE;
                    end else begin
                        w_rd_en = 1'b1;
                        n_scan  = r_scan + IDX_W'(1);
                    end
                end
            end
            pts_pkg::ST_DONE: begin
                // Final word of the item carries last
                w_rep.last = 1'b1;
                if (w_can_push) begin
                    w_push  = 1'b1;
                    n_state = pts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/pts_checker.sv
module pts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_kind,
    input logic        o_accepted,
    input logic [3:0]  o_task_index,
    input logic        o_fired,
    input logic        o_last
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_accepted) &&
            $stable(o_task_index) && $stable(o_fired) && $stable(o_last))
        else $error("output word changed while stalled");

    // A register reply is a single word and never reports a fire
    a_reply_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == pts_pkg::KIND_REPLY |-> o_last && !o_fired)
        else $error("malformed register reply");

    // Run reports never claim acceptance
    a_run_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == pts_pkg::KIND_RUN |-> !o_accepted)
        else $error("run report with accepted set");

    // Nothing-fired report closes its pass with slot zero
    a_run_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == pts_pkg::KIND_RUN && !o_fired |->
            o_last && o_task_index == 4'd0)
        else $error("malformed empty run report");

endmodule

bind periodic_task_scheduler_unit pts_checker u_pts_checker (.*);

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS      = 16;
    localparam int          IDLE_LIMIT = 3000;
    localparam int          TAIL_WAIT  = 40;
    localparam int          MAX_PRINTS = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_op = pts_pkg::OP_REGISTER;
    logic [31:0] i_now = '0;
    logic [31:0] i_period = '0;
    logic [31:0] i_start_delay = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_kind;
    logic        o_accepted;
    logic [3:0]  o_task_index;
    logic        o_fired;
    logic        o_last;

    // Scheduler mirror: task table and its fill level
    logic [5:0]  sched_count = '0;
    logic [31:0] sched_period [SLOTS];
    logic [31:0] sched_last_run [SLOTS];

    pts_pkg::t_report expected_reports[$];
    int          err_count = 0;
    int          idle_cycles = 0;
    int          ready_stall = 0;
    bit          quiet = 1'b0;
    logic [31:0] tick = '0;

    periodic_task_scheduler_unit #(
        .TASK_SLOTS(SLOTS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_now         (i_now),
        .i_period      (i_period),
        .i_start_delay (i_start_delay),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_accepted    (o_accepted),
        .o_task_index  (o_task_index),
        .o_fired       (o_fired),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none while quiet
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Expected reports for one accepted input word
    task automatic predict_schedule(input logic op, input logic [31:0] now,
                                    input logic [31:0] period, input logic [31:0] delay);
        pts_pkg::t_report rep;
        int      n;
        n = 0;
        rep = '0;
        if (op == pts_pkg::OP_REGISTER) begin
            rep.kind = pts_pkg::KIND_REPLY;
            rep.last = 1'b1;
            if (sched_count < SLOTS) begin
                sched_period[sched_count]   = period;
                sched_last_run[sched_count] = now + delay - period;
                rep.accepted   = 1'b1;
                rep.task_index = sched_count[3:0];
                sched_count++;
            end
            expected_reports.push_back(rep);
        end else begin
            rep.kind = pts_pkg::KIND_RUN;
            for (int i = 0; i < sched_count && n < pts_pkg::MAX_REPORTS; i++) begin
                if (32'(now - sched_last_run[i]) >= sched_period[i]) begin
                    sched_last_run[i] = now;
                    rep.task_index = i[3:0];
                    rep.fired = 1'b1;
                    expected_reports.push_back(rep);
                    n++;
                end
            end
            if (n == 0) begin
                rep.last = 1'b1;
                expected_reports.push_back(rep);
            end else begin
                rep = expected_reports.pop_back();
                rep.last = 1'b1;
                expected_reports.push_back(rep);
            end
        end
    endtask

    // Send one word; entered and left at a falling edge, valid stays high on exit
    task automatic send_word(input logic op, input logic [31:0] now,
                             input logic [31:0] period, input logic [31:0] delay);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op          = op;
        i_now         = now;
        i_period      = period;
        i_start_delay = delay;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_schedule(op, now, period, delay);
        @(negedge i_clk);
    endtask

    // Hold the sender until every expected report has come back
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_pass(input logic [31:0] now);
        send_word(pts_pkg::OP_RUN, now, $urandom, $urandom);
    endtask

    task automatic test_empty_table();
        run_pass(32'd0);
    endtask

    // Registration with extreme and wrapping fields
    task automatic test_register_extremes();
        send_word(pts_pkg::OP_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(pts_pkg::OP_REGISTER, 32'd100, 32'd10, 32'd0);
        send_word(pts_pkg::OP_REGISTER, 32'd100, 32'd5, 32'd20);
        send_word(pts_pkg::OP_REGISTER, 32'hFFFF_FFF0, 32'h20, 32'd8);
    endtask

    // Passes around due points, a repeat with nothing due, and tick wrap
    task automatic test_run_passes();
        run_pass(32'd99);
        run_pass(32'd100);
        run_pass(32'd100);
        run_pass(32'd120);
        run_pass(32'hFFFF_FFFE);
        run_pass(32'hFFFF_FFFF);
        run_pass(32'd0);
        wait_drained();
        tick = 32'd200;
    endtask

    // Mixed registers and passes while time moves forward
    task automatic test_random_traffic(input int count);
        logic [31:0] period;
        logic [31:0] delay;
        int          r;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 8) quiet = !quiet;
            if ($urandom_range(0, 99) < 5) wait_drained();
            r = $urandom_range(0, 99);
            if (sched_count < SLOTS - 2 && r < 30) begin
                r = $urandom_range(0, 99);
                period = (r < 80) ? 32'($urandom_range(1, 40)) : ($urandom | 32'd1);
                delay  = (r % 4 != 0) ? 32'($urandom_range(0, 30)) : $urandom;
                send_word(pts_pkg::OP_REGISTER, tick, period, delay);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) tick += $urandom_range(0, 15);
                else if (r < 90) tick += $urandom_range(16, 200);
                else tick = $urandom;
                run_pass(tick);
            end
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    // Fill the last slots, then registrations against a full table
    task automatic test_table_full();
        while (sched_count < SLOTS - 2)
            send_word(pts_pkg::OP_REGISTER, tick, $urandom_range(1, 40),
                      $urandom_range(0, 30));
        send_word(pts_pkg::OP_REGISTER, tick, 32'd0, 32'd0);
        send_word(pts_pkg::OP_REGISTER, tick, 32'd7, 32'd0);
        send_word(pts_pkg::OP_REGISTER, 32'd0, 32'd0, 32'd0);
        send_word(pts_pkg::OP_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(pts_pkg::OP_REGISTER, $urandom, $urandom, $urandom);
        // far jump fires most slots; the repeat fires only the zero-period one
        tick += 32'd100000;
        run_pass(tick);
        run_pass(tick);
        wait_drained();
    endtask

    // Passes on a full table with the odd rejected registration
    task automatic test_random_runs(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 8) quiet = !quiet;
            if ($urandom_range(0, 99) < 5) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_word(pts_pkg::OP_REGISTER, $urandom, $urandom, $urandom);
            end else begin
                if (r < 70) tick += $urandom_range(0, 15);
                else if (r < 92) tick += $urandom_range(16, 300);
                else tick = $urandom;
                run_pass(tick);
            end
        end
        quiet = 1'b0;
    endtask

    // Result side: random stalls on ready
    always @(negedge i_clk) begin
        if (ready_stall > 0) begin
            i_out_ready <= 1'b0;
            ready_stall <= ready_stall - 1;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30) ready_stall <= pick_gap();
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        pts_pkg::t_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind=%0d index=%0d",
                                          o_kind, o_task_index));
            end else begin
                want = expected_reports.pop_front();
                check_field("kind", o_kind, want.kind);
                check_field("accepted", o_accepted, want.accepted);
                check_field("task_index", o_task_index, want.task_index);
                check_field("fired", o_fired, want.fired);
                check_field("last", o_last, want.last);
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_register_extremes();
        test_run_passes();
        test_random_traffic(60);
        test_table_full();
        test_random_runs(40);

        wait_drained();
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (expected_reports.size() != 0)
            report_mismatch($sformatf("%0d expected words never came",
                                      expected_reports.size()));
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
